// ===== src/rational_arithmetic_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit assertion macros
// Shared property wrappers for the clock and reset of the block.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// Same-cycle implication.
`define RAU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Word width, operation codes and the control link to the shared unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rau_pkg;

  localparam int WordBits  = 64;
  localparam int FieldBits = 64;
  localparam int CntBits   = $clog2(WordBits);

  typedef logic [WordBits-1:0]  word_t;
  typedef logic [FieldBits-1:0] field_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_RED = 3'd4,
    OP_CMP = 3'd5
  } op_e;

  typedef struct packed {
    logic start;
    logic is_div;
  } rau_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rau_sts_t;

  function automatic logic is_neg(word_t x);
    return x[WordBits-1];
  endfunction

  function automatic word_t magn(word_t x);
    return x[WordBits-1] ? ('0 - x) : x;
  endfunction

  // Sign extend a word to the field width.
  function automatic field_t to_field(word_t x);
    return FieldBits'(signed'(x));
  endfunction

endpackage

// ===== src/rau_if.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit channels
// Input and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rau_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [63:0] a_num;
  logic [63:0] a_den;
  logic [63:0] b_num;
  logic [63:0] b_den;

  modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] res_num;
  logic [63:0] res_den;
  logic        less;
  logic        equal;
  logic        greater;
  logic        div_zero;

  modport source (output valid, res_num, res_den, less, equal, greater, div_zero,
                  input ready);
  modport sink   (input valid, res_num, res_den, less, equal, greater, div_zero,
                  output ready);
endinterface

// ===== src/rau_iter.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit iterative engine
// Shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rau_iter
  import rau_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rau_cmd_t cmd_i,
  input  word_t    opa_i,
  input  word_t    opb_i,
  output rau_sts_t sts_o,
  output word_t    lo_o,
  output word_t    hi_o
);

  logic               busy_q, done_q, div_q;
  logic [CntBits-1:0] cnt_q;
  word_t              sh_q, aux_q, acc_q;

  logic [WordBits:0]  rs, diff;

  // rs holds partial remainder with next dividend bit
  assign rs   = {acc_q, sh_q[WordBits-1]};
  assign diff = rs - {1'b0, aux_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      div_q  <= 1'b0;
      cnt_q  <= '0;
      sh_q   <= '0;
      aux_q  <= '0;
      acc_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start && !busy_q) begin
        busy_q <= 1'b1;
        div_q  <= cmd_i.is_div;
        cnt_q  <= '0;
        sh_q   <= opa_i;
        aux_q  <= opb_i;
        acc_q  <= '0;
      end else if (busy_q) begin
        if (div_q) begin
          if (!diff[WordBits]) begin
            acc_q <= diff[WordBits-1:0];
            sh_q  <= {sh_q[WordBits-2:0], 1'b1};
          end else begin
            acc_q <= rs[WordBits-1:0];
            sh_q  <= {sh_q[WordBits-2:0], 1'b0};
          end
        end else begin
          if (aux_q[0]) acc_q <= acc_q + sh_q;
          sh_q  <= {sh_q[WordBits-2:0], 1'b0};
          aux_q <= {1'b0, aux_q[WordBits-1:1]};
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntBits'(WordBits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign lo_o       = div_q ? sh_q : acc_q;  // quotient or product
  assign hi_o       = acc_q;                 // remainder

endmodule

// ===== src/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Fraction add, subtract, multiply, divide, compare and reduce on one
// shared bit-serial multiply/divide engine.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake     Payload
// in_i     in   valid/ready   op, a_num, a_den, b_num, b_den
// out_o    out  valid/ready   res_num, res_den, less, equal, greater, div_zero
//
// Add/subtract: 3 passes of the shared engine; multiply, divide, compare: 2
// passes. Reduce: one divide pass per Euclid remainder step (up to about 92)
// plus two quotient passes. Unused codes go straight to the done state.
// in_i.ready is high only while idle; a finished item waits in the output
// register, and the next item is taken meanwhile. Reset is asynchronous.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_macros.svh"

module rational_arithmetic_unit
  import rau_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  rau_in_if.sink    in_i,
  rau_out_if.source out_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_ISSUE, S_MUL, S_GCD, S_REM, S_QN, S_QD, S_DONE
  } state_e;

  state_e   state_q;
  op_e      op_q;
  word_t    an_q, ad_q, bn_q, bd_q, x_q, y_q, p0_q, p1_q, qn_q;
  logic [1:0] mstep_q;
  logic     go_q, udiv_q;
  word_t    ua_q, ub_q;
  word_t    rn_q, rd_q;
  logic     lt_q, eq_q, gt_q, dz_q;
  logic     ov_q;
  word_t    on_q, od_q;
  logic     olt_q, oeq_q, ogt_q, odz_q;

  rau_cmd_t cmd;
  rau_sts_t sts;
  word_t    u_lo, u_hi;
  word_t    ma, mb, in_an, in_ad, rem_s, q_s, qd_fix, qn_fix;
  logic     last_step;

  assign cmd.start  = go_q;
  assign cmd.is_div = udiv_q;

  rau_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .opa_i  (ua_q),
    .opb_i  (ub_q),
    .sts_o  (sts),
    .lo_o   (u_lo),
    .hi_o   (u_hi)
  );

  assign in_an = in_i.a_num[WordBits-1:0];
  assign in_ad = in_i.a_den[WordBits-1:0];

  // Operand pair for the current multiply pass
  always_comb begin
    ma = an_q;
    mb = bd_q;
    case (op_q)
      OP_MUL: begin
        ma = (mstep_q == 2'd0) ? an_q : ad_q;
        mb = (mstep_q == 2'd0) ? bn_q : bd_q;
      end
      OP_DIV: begin
        ma = (mstep_q == 2'd0) ? an_q : ad_q;
        mb = (mstep_q == 2'd0) ? bd_q : bn_q;
      end
      default: begin
        case (mstep_q)
          2'd0:    begin ma = an_q; mb = bd_q; end
          2'd1:    begin ma = bn_q; mb = ad_q; end
          default: begin ma = bd_q; mb = ad_q; end
        endcase
      end
    endcase
  end

  assign last_step = (op_q == OP_ADD || op_q == OP_SUB) ? (mstep_q == 2'd2)
                                                        : (mstep_q == 2'd1);

  assign rem_s = is_neg(x_q) ? ('0 - u_hi) : u_hi;
  // x_q holds the gcd during the quotient passes
  assign q_s   = (is_neg(op_q == OP_RED && state_q == S_QN ? an_q : ad_q) != is_neg(x_q))
                 ? ('0 - u_lo) : u_lo;
  assign qn_fix = is_neg(q_s) ? ('0 - qn_q) : qn_q;
  assign qd_fix = is_neg(q_s) ? ('0 - q_s) : q_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_ADD;
      {an_q, ad_q, bn_q, bd_q, x_q, y_q, p0_q, p1_q, qn_q} <= '0;
      mstep_q <= '0;
      go_q    <= 1'b0;
      udiv_q  <= 1'b0;
      ua_q    <= '0;
      ub_q    <= '0;
      {rn_q, rd_q, lt_q, eq_q, gt_q, dz_q} <= '0;
      ov_q    <= 1'b0;
      {on_q, od_q, olt_q, oeq_q, ogt_q, odz_q} <= '0;
    end else begin
      go_q <= 1'b0;
      if (out_o.ready) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            op_q    <= op_e'(in_i.op);
            an_q    <= in_an;
            ad_q    <= in_ad;
            bn_q    <= in_i.b_num[WordBits-1:0];
            bd_q    <= in_i.b_den[WordBits-1:0];
            mstep_q <= '0;
            {rn_q, rd_q, lt_q, eq_q, gt_q, dz_q} <= '0;
            if (signed'(in_an) < signed'(in_ad)) begin
              x_q <= in_ad;
              y_q <= in_an;
            end else begin
              x_q <= in_an;
              y_q <= in_ad;
            end
            case (op_e'(in_i.op))
              OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP: state_q <= S_ISSUE;
              OP_RED:                                 state_q <= S_GCD;
              default:                                state_q <= S_DONE;
            endcase
          end
        end
        S_ISSUE: begin
          ua_q    <= ma;
          ub_q    <= mb;
          udiv_q  <= 1'b0;
          go_q    <= 1'b1;
          state_q <= S_MUL;
        end
        S_MUL: begin
          if (sts.done) begin
            mstep_q <= mstep_q + 2'd1;
            if (mstep_q == 2'd0) p0_q <= u_lo;
            if (mstep_q == 2'd1) p1_q <= u_lo;
            if (!last_step) begin
              state_q <= S_ISSUE;
            end else begin
              state_q <= S_DONE;
              case (op_q)
                OP_ADD: begin rn_q <= p0_q + p1_q; rd_q <= u_lo; end
                OP_SUB: begin rn_q <= p0_q - p1_q; rd_q <= u_lo; end
                OP_CMP: begin
                  lt_q <= signed'(p0_q) < signed'(u_lo);
                  gt_q <= signed'(u_lo) < signed'(p0_q);
                  eq_q <= p0_q == u_lo;
                end
                default: begin rn_q <= p0_q; rd_q <= u_lo; end
              endcase
            end
          end
        end
        S_GCD: begin
          udiv_q <= 1'b1;
          if (y_q != '0) begin
            ua_q    <= magn(x_q);
            ub_q    <= magn(y_q);
            go_q    <= 1'b1;
            state_q <= S_REM;
          end else if (x_q == '0) begin
            rn_q    <= an_q;
            rd_q    <= ad_q;
            dz_q    <= 1'b1;
            state_q <= S_DONE;
          end else begin
            ua_q    <= magn(an_q);
            ub_q    <= magn(x_q);
            go_q    <= 1'b1;
            state_q <= S_QN;
          end
        end
        S_REM: begin
          if (sts.done) begin
            x_q     <= y_q;
            y_q     <= rem_s;
            state_q <= S_GCD;
          end
        end
        S_QN: begin
          if (sts.done) begin
            qn_q    <= q_s;
            ua_q    <= magn(ad_q);
            ub_q    <= magn(x_q);
            go_q    <= 1'b1;
            state_q <= S_QD;
          end
        end
        S_QD: begin
          if (sts.done) begin
            // make the denominator positive
            rn_q    <= qn_fix;
            rd_q    <= qd_fix;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!ov_q || out_o.ready) begin
            ov_q    <= 1'b1;
            on_q    <= rn_q;
            od_q    <= rd_q;
            olt_q   <= lt_q;
            oeq_q   <= eq_q;
            ogt_q   <= gt_q;
            odz_q   <= dz_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready     = (state_q == S_IDLE);
  assign out_o.valid    = ov_q;
  assign out_o.res_num  = to_field(on_q);
  assign out_o.res_den  = to_field(od_q);
  assign out_o.less     = olt_q;
  assign out_o.equal    = oeq_q;
  assign out_o.greater  = ogt_q;
  assign out_o.div_zero = odz_q;

  `RAU_ASSERT_NOW(a_start_idle, go_q, !sts.busy, "engine started while busy")
  `RAU_ASSERT_NOW(a_flags_one, ov_q, $onehot0({olt_q, oeq_q, ogt_q}), "compare flags clash")
  `RAU_ASSERT_NOW(a_dz_clean, ov_q && odz_q, !olt_q && !oeq_q && !ogt_q,
                  "div_zero with compare flags")
  `RAU_ASSERT_NEXT(a_accept_busy, in_i.valid && in_i.ready, state_q != S_IDLE,
                   "item accepted but block stayed idle")

endmodule

// ===== test/tb_rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives fraction items through the input channel, predicts each result with
// a local wrapped 64-bit model and checks results in order on the output
// channel, under several idling phases and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rational_arithmetic_unit
  import rau_pkg::*;
();

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] a_num;
    logic [63:0] a_den;
    logic [63:0] b_num;
    logic [63:0] b_den;
  } frac_item_t;

  typedef struct packed {
    logic [63:0] res_num;
    logic [63:0] res_den;
    logic        less;
    logic        equal;
    logic        greater;
    logic        div_zero;
  } frac_res_t;

  localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxVal = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] MinusOne = '1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rau_in_if  in_ch();
  rau_out_if out_ch();

  rational_arithmetic_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  frac_item_t pending_items[$];
  frac_res_t  expected_results[$];
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_off_cycles = 0;
  int         mismatches = 0;

  function automatic logic [63:0] trunc_rem(logic [63:0] x, logic [63:0] y);
    logic [63:0] r;
    r = magn(x) % magn(y);
    return x[63] ? -r : r;
  endfunction

  function automatic logic [63:0] trunc_div(logic [63:0] x, logic [63:0] y);
    logic [63:0] q;
    q = magn(x) / magn(y);
    return (x[63] != y[63]) ? -q : q;
  endfunction

  function automatic frac_res_t predict_fraction(frac_item_t it);
    frac_res_t   r;
    logic [63:0] x, y, t, p, q;
    r = '0;
    case (it.op)
      OP_ADD: begin
        r.res_num = it.a_num * it.b_den + it.b_num * it.a_den;
        r.res_den = it.b_den * it.a_den;
      end
      OP_SUB: begin
        r.res_num = it.a_num * it.b_den - it.b_num * it.a_den;
        r.res_den = it.b_den * it.a_den;
      end
      OP_MUL: begin
        r.res_num = it.a_num * it.b_num;
        r.res_den = it.a_den * it.b_den;
      end
      OP_DIV: begin
        r.res_num = it.a_num * it.b_den;
        r.res_den = it.a_den * it.b_num;
      end
      OP_RED: begin
        if ($signed(it.a_num) < $signed(it.a_den)) begin
          x = it.a_den; y = it.a_num;
        end else begin
          x = it.a_num; y = it.a_den;
        end
        while (y != 0) begin
          t = trunc_rem(x, y);
          x = y;
          y = t;
        end
        if (x == 0) begin
          r.res_num = it.a_num;
          r.res_den = it.a_den;
          r.div_zero = 1'b1;
        end else begin
          r.res_num = trunc_div(it.a_num, x);
          r.res_den = trunc_div(it.a_den, x);
          if (r.res_den[63]) begin
            r.res_num = -r.res_num;
            r.res_den = -r.res_den;
          end
        end
      end
      OP_CMP: begin
        p = it.a_num * it.b_den;
        q = it.b_num * it.a_den;
        r.less = $signed(p) < $signed(q);
        r.greater = $signed(q) < $signed(p);
        r.equal = p == q;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Mostly small magnitudes keep Euclid short; some full-width values.
  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    case ($urandom_range(0, 5))
      0: w = {$urandom, $urandom};
      1: w = $urandom_range(0, 3) == 0 ? MinVal : MaxVal;
      2: w = 64'($signed($urandom_range(0, 40)) - 20);
      default: w = 64'($signed($urandom_range(0, 2000)) - 1000);
    endcase
    return w;
  endfunction

  task automatic queue_item(logic [2:0] op, logic [63:0] an, logic [63:0] ad,
                            logic [63:0] bn, logic [63:0] bd);
    frac_item_t it;
    it.op = op; it.a_num = an; it.a_den = ad; it.b_num = bn; it.b_den = bd;
    pending_items.push_back(it);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic queue_random(int count);
    logic [2:0] op;
    repeat (count) begin
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                        : 3'($urandom_range(0, 5));
      queue_item(op, rand_word(), rand_word(), rand_word(),
                 ($urandom_range(0, 3) == 0) ? 64'd1 : rand_word());
    end
  endtask

  // Driver: hold the item until accepted, then advance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.op <= '0;
      in_ch.a_num <= '0;
      in_ch.a_den <= '0;
      in_ch.b_num <= '0;
      in_ch.b_den <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) expected_results.push_back(predict_fraction(
          {in_ch.op, in_ch.a_num, in_ch.a_den, in_ch.b_num, in_ch.b_den}));
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        frac_item_t it;
        it = pending_items.pop_front();
        in_ch.valid <= 1'b1;
        {in_ch.op, in_ch.a_num, in_ch.a_den, in_ch.b_num, in_ch.b_den} <= it;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Long output hold-off, counted here.
  int hold_count = 0;
  always @(posedge clk_i) begin
    if (hold_off_cycles != 0) begin
      hold_count <= hold_off_cycles;
      hold_off_cycles <= 0;
    end else if (hold_count != 0) begin
      hold_count <= hold_count - 1;
    end
  end

  // Monitor: check each accepted result against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        frac_res_t got, want;
        got = {out_ch.res_num, out_ch.res_den, out_ch.less, out_ch.equal,
               out_ch.greater, out_ch.div_zero};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected num %h den %h lt %b eq %b gt %b dz %b,",
                       want.res_num, want.res_den, want.less, want.equal,
                       want.greater, want.div_zero,
                       " got num %h den %h lt %b eq %b gt %b dz %b",
                       got.res_num, got.res_den, got.less, got.equal,
                       got.greater, got.div_zero);
          end
        end
      end
      out_ch.ready <= (hold_count == 0 && hold_off_cycles == 0) &&
                      ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: extremes, every op, zero gcd, wrap cases, unused codes.
    queue_item(OP_ADD, 64'd1, 64'd2, 64'd1, 64'd3);
    queue_item(OP_SUB, MinVal, 64'd1, 64'd1, 64'd1);
    queue_item(OP_MUL, MaxVal, MaxVal, MinusOne, MinVal);
    queue_item(OP_DIV, 64'd3, 64'd4, 64'd0, 64'd5);
    queue_item(OP_ADD, '1, '1, '1, '1);
    queue_item(OP_CMP, 64'd1, 64'd2, 64'd2, 64'd4);
    queue_item(OP_CMP, 64'd1, 64'd3, 64'd1, 64'd2);
    queue_item(OP_CMP, MinVal, 64'd1, MaxVal, 64'd1);
    queue_item(OP_RED, 64'd0, 64'd0, 64'd0, 64'd0);
    queue_item(OP_RED, 64'd6, 64'd4, 64'd0, 64'd0);
    queue_item(OP_RED, 64'd6, -64'd4, 64'd0, 64'd0);
    queue_item(OP_RED, MinVal, MinusOne, 64'd0, 64'd0);
    queue_item(OP_RED, MinVal, MinVal, 64'd0, 64'd0);
    queue_item(OP_RED, 64'd0, -64'd7, 64'd0, 64'd0);
    queue_item(OP_RED, MaxVal, MinVal, 64'd0, 64'd0);
    queue_item(OP_RED, 64'd89, 64'd55, 64'd0, 64'd0);
    queue_item(3'd6, '1, '1, '1, '1);
    queue_item(3'd7, 64'd5, 64'd5, 64'd5, 64'd5);
    queue_item(OP_DIV, {32'h5555_5555, 32'haaaa_aaaa}, 64'd1, MinVal, 64'd1);
    wait_drained();
    queue_random(25);
    wait_drained();
    send_idle_pct = 77;
    queue_random(25);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 77;
    queue_random(25);
    wait_drained();
    send_idle_pct = 23;
    recv_stall_pct = 23;
    hold_off_cycles = 3000;
    queue_random(25);
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("tb_rational_arithmetic_unit: done, clean");
    else
      $display("tb_rational_arithmetic_unit: done, errors");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("tb_rational_arithmetic_unit: done, errors");
    $finish;
  end

endmodule

// ===== rational_arithmetic_unit.f =====
+incdir+src
src/rau_pkg.sv
src/rau_if.sv
src/rau_iter.sv
src/rational_arithmetic_unit.sv
test/tb_rational_arithmetic_unit.sv
